[rtl/assert_macros.svh]
// Assertion macros for the deframer RTL, included by the core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define ARD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("Deframer assertion failed.");

// Checks that a condition never holds while reset is released.
`define ARD_ASSERT_NEVER(name, clk, rst_n, cond) \
  `ARD_ASSERT(name, clk, rst_n, !(cond))

`endif

[rtl/ard_pkg.sv]
// Package with the shared types and defaults of the archive record deframer.
`default_nettype none

package ard_pkg;

  localparam int HeaderBytesDef = 13;
  localparam int SizeBitsDef    = 32;
  localparam int FileSizeW      = 32;
  localparam int VersionW       = 16;

  typedef enum logic [3:0] {
    KindHeader   = 4'd0,
    KindVersion  = 4'd1,
    KindMetaLen  = 4'd2,
    KindMetaText = 4'd3,
    KindRecType  = 4'd4,
    KindNameLen  = 4'd5,
    KindName     = 4'd6,
    KindSize     = 4'd7,
    KindData     = 4'd8,
    KindMarkLen  = 4'd9,
    KindMark     = 4'd10,
    KindUnknown  = 4'd11,
    KindIgnored  = 4'd12
  } byte_kind_e;

  typedef struct packed {
    byte_kind_e             byte_kind;
    logic [7:0]             byte_value;
    logic [2:0]             meta_index;
    logic                   item_last;
    logic [FileSizeW-1:0]   file_size;
    logic                   size_overflow;
    logic [VersionW-1:0]    version;
  } ard_result_t;

endpackage

`default_nettype wire

[rtl/ard_if.sv]
// Handshake interfaces for the deframer byte input and tagged result output.
`default_nettype none

interface ard_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;

  modport source (output valid, output data_byte, output stream_start, input ready);
  modport sink (input valid, input data_byte, input stream_start, output ready);
endinterface

interface ard_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  byte_kind;
  logic [7:0]  byte_value;
  logic [2:0]  meta_index;
  logic        item_last;
  logic [31:0] file_size;
  logic        size_overflow;
  logic [15:0] version;

  modport source (
    output valid, output byte_kind, output byte_value, output meta_index,
    output item_last, output file_size, output size_overflow, output version,
    input ready
  );
  modport sink (
    input valid, input byte_kind, input byte_value, input meta_index,
    input item_last, input file_size, input size_overflow, input version,
    output ready
  );
endinterface

`default_nettype wire

[rtl/ard_parser.sv]
// Phase machine and counters that classify one archive byte per step.
`default_nettype none

module ard_parser import ard_pkg::*; #(
  parameter int HEADER_BYTES = HeaderBytesDef,
  parameter int SIZE_BITS    = SizeBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        stream_start_i,
  output ard_result_t      result_o
);

  localparam int AccW = (SIZE_BITS >= FileSizeW) ? FileSizeW : SIZE_BITS;
  localparam int HdrW = (HEADER_BYTES < 2) ? 1 : $clog2(HEADER_BYTES + 1);
  localparam logic [HdrW-1:0] HdrLimit = HdrW'(HEADER_BYTES);
  localparam logic [2:0] MetaStrings = 3'd7;

  localparam logic [3:0] PhHeader  = 4'd0;
  localparam logic [3:0] PhVerHi   = 4'd1;
  localparam logic [3:0] PhVerLo   = 4'd2;
  localparam logic [3:0] PhMetaLen = 4'd3;
  localparam logic [3:0] PhMetaTxt = 4'd4;
  localparam logic [3:0] PhRecType = 4'd5;
  localparam logic [3:0] PhNameLen = 4'd6;
  localparam logic [3:0] PhName    = 4'd7;
  localparam logic [3:0] PhSize    = 4'd8;
  localparam logic [3:0] PhData    = 4'd9;
  localparam logic [3:0] PhMarkLen = 4'd10;
  localparam logic [3:0] PhMark    = 4'd11;
  localparam logic [3:0] PhIgnored = 4'd12;

  logic [3:0]          phase_q, phase_d, phase_s;
  logic [AccW-1:0]     left_q, left_d, left_s, left_dec;
  logic [AccW-1:0]     acc_q, acc_d, acc_s;
  logic [HdrW-1:0]     hdr_q, hdr_d, hdr_s, hdr_inc;
  logic [VersionW-1:0] ver_q, ver_d, ver_s;
  logic [2:0]          meta_q, meta_d, meta_s, meta_inc;
  logic                ovf_q, ovf_d, ovf_s;
  logic [7:0]          b;

  assign b        = data_byte_i;
  assign left_dec = left_s - AccW'(1);
  assign hdr_inc  = hdr_s + HdrW'(1);
  assign meta_inc = meta_s + 3'd1;

  always_comb begin
    logic [3:0] ph_raw;
    ph_raw = stream_start_i ? PhHeader : phase_q;
    left_s = stream_start_i ? '0 : left_q;
    acc_s  = stream_start_i ? '0 : acc_q;
    hdr_s  = stream_start_i ? '0 : hdr_q;
    ver_s  = stream_start_i ? '0 : ver_q;
    meta_s = stream_start_i ? '0 : meta_q;
    ovf_s  = stream_start_i ? 1'b0 : ovf_q;
    phase_s = ((ph_raw == PhHeader) && (hdr_s >= HdrLimit)) ? PhVerHi : ph_raw;
  end

  always_comb begin
    phase_d = phase_s;
    left_d  = left_s;
    acc_d   = acc_s;
    hdr_d   = hdr_s;
    ver_d   = ver_s;
    meta_d  = meta_s;
    ovf_d   = ovf_s;

    result_o               = '0;
    result_o.byte_kind     = KindIgnored;
    result_o.byte_value    = b;

    unique case (phase_s)
      PhHeader: begin
        result_o.byte_kind = KindHeader;
        hdr_d = hdr_inc;
        if (hdr_inc >= HdrLimit) begin
          phase_d = PhVerHi;
        end
      end
      PhVerHi: begin
        result_o.byte_kind = KindVersion;
        ver_d   = {b, 8'h00};
        phase_d = PhVerLo;
      end
      PhVerLo: begin
        result_o.byte_kind = KindVersion;
        ver_d = {ver_s[15:8], b};
        if ({ver_s[15:8], b} == 16'd1) begin
          phase_d = PhRecType;
        end else if ({ver_s[15:8], b} == 16'd2) begin
          meta_d  = '0;
          phase_d = PhMetaLen;
        end else begin
          phase_d = PhIgnored;
        end
      end
      PhMetaLen: begin
        result_o.byte_kind  = KindMetaLen;
        result_o.meta_index = meta_s;
        left_d = AccW'(b);
        if (b == 8'h00) begin
          meta_d  = meta_inc;
          phase_d = (meta_inc == MetaStrings) ? PhRecType : PhMetaLen;
        end else begin
          phase_d = PhMetaTxt;
        end
      end
      PhMetaTxt: begin
        result_o.byte_kind  = KindMetaText;
        result_o.meta_index = meta_s;
        left_d = left_dec;
        if (left_dec == '0) begin
          result_o.item_last = 1'b1;
          meta_d  = meta_inc;
          phase_d = (meta_inc == MetaStrings) ? PhRecType : PhMetaLen;
        end
      end
      PhRecType: begin
        if (b == 8'h00) begin
          result_o.byte_kind = KindRecType;
          phase_d = PhNameLen;
        end else if (b == 8'hFF) begin
          result_o.byte_kind = KindRecType;
          phase_d = PhMarkLen;
        end else begin
          result_o.byte_kind = KindUnknown;
        end
      end
      PhNameLen: begin
        result_o.byte_kind = KindNameLen;
        left_d  = AccW'(b);
        acc_d   = '0;
        ovf_d   = 1'b0;
        phase_d = (b == 8'h00) ? PhSize : PhName;
      end
      PhName: begin
        result_o.byte_kind = KindName;
        left_d = left_dec;
        if (left_dec == '0) begin
          result_o.item_last = 1'b1;
          phase_d = PhSize;
        end
      end
      PhSize: begin
        result_o.byte_kind = KindSize;
        if (ovf_s || (acc_s[AccW-1 -: 7] != 7'd0)) begin
          ovf_d = 1'b1;
          acc_d = '1;
        end else begin
          acc_d = {acc_s[AccW-8:0], b[6:0]};
        end
        result_o.file_size     = FileSizeW'(acc_d);
        result_o.size_overflow = ovf_d;
        if (!b[7]) begin
          result_o.item_last = 1'b1;
          left_d  = acc_d;
          phase_d = (acc_d == '0) ? PhRecType : PhData;
        end
      end
      PhData: begin
        result_o.byte_kind = KindData;
        left_d = left_dec;
        if (left_dec == '0) begin
          result_o.item_last = 1'b1;
          phase_d = PhRecType;
        end
      end
      PhMarkLen: begin
        result_o.byte_kind = KindMarkLen;
        left_d  = AccW'(b);
        phase_d = (b == 8'h00) ? PhRecType : PhMark;
      end
      PhMark: begin
        result_o.byte_kind = KindMark;
        left_d = left_dec;
        if (left_dec == '0) begin
          result_o.item_last = 1'b1;
          phase_d = PhRecType;
        end
      end
      default: begin
        result_o.byte_kind = KindIgnored;
      end
    endcase

    result_o.version = ver_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      left_q  <= '0;
      acc_q   <= '0;
      hdr_q   <= '0;
      ver_q   <= '0;
      meta_q  <= '0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
      hdr_q   <= hdr_d;
      ver_q   <= ver_d;
      meta_q  <= meta_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

[rtl/archive_record_deframer_core.sv]
// Top level of the archive record deframer: handshake and result register.
// The deframer accepts one archive byte per clock cycle while in_i.ready is high and returns
// exactly one tagged result transaction for each byte, in the cycle after acceptance. The phase
// machine and its counters update in the accepting cycle, so throughput is one byte per cycle
// whenever the sink takes results; the single output register sets that figure, and input ready
// follows the output register being empty or being drained in the same cycle. A byte with
// stream_start set restarts the parser as if from reset before it is classified.
`default_nettype none

`include "assert_macros.svh"

module archive_record_deframer_core import ard_pkg::*; #(
  parameter int HEADER_BYTES = HeaderBytesDef,
  parameter int SIZE_BITS    = SizeBitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ard_in_if.sink     in_i,
  ard_out_if.source  out_o
);

  logic        accept;
  logic        out_valid_q, out_valid_d;
  ard_result_t result;
  ard_result_t result_q;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign out_valid_d = accept || (out_valid_q && !out_o.ready);

  ard_parser #(
    .HEADER_BYTES (HEADER_BYTES),
    .SIZE_BITS    (SIZE_BITS)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (accept),
    .data_byte_i    (in_i.data_byte),
    .stream_start_i (in_i.stream_start),
    .result_o       (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.byte_kind     = result_q.byte_kind;
  assign out_o.byte_value    = result_q.byte_value;
  assign out_o.meta_index    = result_q.meta_index;
  assign out_o.item_last     = result_q.item_last;
  assign out_o.file_size     = result_q.file_size;
  assign out_o.size_overflow = result_q.size_overflow;
  assign out_o.version       = result_q.version;

  `ARD_ASSERT(a_accept_gives_result, clk_i, rst_ni, accept |=> out_o.valid)
  `ARD_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_q |-> in_i.ready)
  `ARD_ASSERT_NEVER(a_overflow_only_on_size, clk_i, rst_ni,
    out_o.valid && out_o.size_overflow && (out_o.byte_kind != KindSize))
  `ARD_ASSERT_NEVER(a_size_only_on_size, clk_i, rst_ni,
    out_o.valid && (out_o.file_size != '0) && (out_o.byte_kind != KindSize))
  `ARD_ASSERT_NEVER(a_meta_index_only_on_meta, clk_i, rst_ni,
    out_o.valid && (out_o.meta_index != 3'd0) && (out_o.byte_kind != KindMetaLen)
    && (out_o.byte_kind != KindMetaText))

endmodule

`default_nettype wire

[dv/archive_record_deframer_core_tb.sv]
// Self-checking testbench for the archive record deframer: byte streams in, tagged bytes out.
`default_nettype none

module archive_record_deframer_core_tb import ard_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          HeaderLen  = HeaderBytesDef;
  localparam logic [63:0] SizeMax    = (SizeBitsDef >= 32) ? 64'hFFFF_FFFF :
                                       ((64'd1 << SizeBitsDef) - 64'd1);
  localparam int          MetaCount  = 7;
  localparam logic [7:0]  RecFile    = 8'h00;
  localparam logic [7:0]  RecMarker  = 8'hFF;
  localparam int          IdleLimit  = 4000;
  localparam int          LongHold   = 400;
  localparam int          TargetSent = 1500;

  typedef enum logic [3:0] {
    PhHeader, PhVerHi, PhVerLo, PhMetaLen, PhMetaText, PhRecType, PhNameLen,
    PhName, PhSize, PhData, PhMarkLen, PhMark, PhIgnored
  } parse_phase_e;

  class ByteTagTracker;
    parse_phase_e phase;
    logic [31:0]  remaining;
    logic [31:0]  size_acc;
    logic [3:0]   hdr_count;
    logic [15:0]  version;
    logic [2:0]   meta_num;
    logic         saturated;
    ard_result_t  expected_tags[$];
    int           errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase     = PhHeader;
      remaining = '0;
      size_acc  = '0;
      hdr_count = '0;
      version   = '0;
      meta_num  = '0;
      saturated = 1'b0;
    endfunction

    function int pending();
      return expected_tags.size();
    endfunction

    function void advance_meta();
      meta_num = meta_num + 3'd1;
      phase = (meta_num >= MetaCount) ? PhRecType : PhMetaLen;
    endfunction

    function void note_byte(logic [7:0] b, logic restart);
      ard_result_t t;
      logic [63:0] grown;
      if (restart) clear();
      t = '0;
      t.byte_kind  = KindIgnored;
      t.byte_value = b;
      if (phase == PhHeader && hdr_count >= HeaderLen) phase = PhVerHi;
      case (phase)
        PhHeader: begin
          t.byte_kind = KindHeader;
          hdr_count = hdr_count + 4'd1;
          if (hdr_count >= HeaderLen) phase = PhVerHi;
        end
        PhVerHi: begin
          t.byte_kind = KindVersion;
          version = {b, 8'h00};
          phase = PhVerLo;
        end
        PhVerLo: begin
          t.byte_kind = KindVersion;
          version[7:0] = b;
          if (version == 16'd1) begin
            phase = PhRecType;
          end else if (version == 16'd2) begin
            meta_num = '0;
            phase = PhMetaLen;
          end else begin
            phase = PhIgnored;
          end
        end
        PhMetaLen: begin
          t.byte_kind  = KindMetaLen;
          t.meta_index = meta_num;
          remaining = {24'd0, b};
          if (b == 8'd0) advance_meta();
          else phase = PhMetaText;
        end
        PhMetaText: begin
          t.byte_kind  = KindMetaText;
          t.meta_index = meta_num;
          remaining = remaining - 32'd1;
          if (remaining == 32'd0) begin
            t.item_last = 1'b1;
            advance_meta();
          end
        end
        PhRecType: begin
          if (b == RecFile) begin
            t.byte_kind = KindRecType;
            phase = PhNameLen;
          end else if (b == RecMarker) begin
            t.byte_kind = KindRecType;
            phase = PhMarkLen;
          end else begin
            t.byte_kind = KindUnknown;
          end
        end
        PhNameLen: begin
          t.byte_kind = KindNameLen;
          remaining = {24'd0, b};
          size_acc  = '0;
          saturated = 1'b0;
          phase = (b == 8'd0) ? PhSize : PhName;
        end
        PhName: begin
          t.byte_kind = KindName;
          remaining = remaining - 32'd1;
          if (remaining == 32'd0) begin
            t.item_last = 1'b1;
            phase = PhSize;
          end
        end
        PhSize: begin
          t.byte_kind = KindSize;
          grown = ({32'd0, size_acc} << 7) | {57'd0, b[6:0]};
          if (saturated || grown > SizeMax) begin
            saturated = 1'b1;
            size_acc = SizeMax[31:0];
          end else begin
            size_acc = grown[31:0];
          end
          t.file_size     = size_acc;
          t.size_overflow = saturated;
          if (!b[7]) begin
            t.item_last = 1'b1;
            remaining = size_acc;
            phase = (remaining == 32'd0) ? PhRecType : PhData;
          end
        end
        PhData: begin
          t.byte_kind = KindData;
          remaining = remaining - 32'd1;
          if (remaining == 32'd0) begin
            t.item_last = 1'b1;
            phase = PhRecType;
          end
        end
        PhMarkLen: begin
          t.byte_kind = KindMarkLen;
          remaining = {24'd0, b};
          phase = (b == 8'd0) ? PhRecType : PhMark;
        end
        PhMark: begin
          t.byte_kind = KindMark;
          remaining = remaining - 32'd1;
          if (remaining == 32'd0) begin
            t.item_last = 1'b1;
            phase = PhRecType;
          end
        end
        default: t.byte_kind = KindIgnored;
      endcase
      t.version = version;
      expected_tags.push_back(t);
    endfunction

    function void compare_field(string name, logic [63:0] e, logic [63:0] a);
      if (a !== e) begin
        $error("%s expected %0d actual %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_tag(ard_result_t got);
      ard_result_t exp;
      if (expected_tags.size() == 0) begin
        $error("Result transaction with no byte waiting, byte_value actual %0d",
               got.byte_value);
        errors++;
        return;
      end
      exp = expected_tags.pop_front();
      compare_field("byte_kind", 64'(exp.byte_kind), 64'(got.byte_kind));
      compare_field("byte_value", 64'(exp.byte_value), 64'(got.byte_value));
      compare_field("meta_index", 64'(exp.meta_index), 64'(got.meta_index));
      compare_field("item_last", 64'(exp.item_last), 64'(got.item_last));
      compare_field("file_size", 64'(exp.file_size), 64'(got.file_size));
      compare_field("size_overflow", 64'(exp.size_overflow), 64'(got.size_overflow));
      compare_field("version", 64'(exp.version), 64'(got.version));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   hold_cycles = 0;
  int   bytes_sent  = 0;
  int   idle_count  = 0;
  int   tx_calm     = 0;
  int   rx_calm     = 0;
  bit   finished    = 1'b0;

  ByteTagTracker tags = new();

  ard_in_if  in_if ();
  ard_out_if out_if ();

  archive_record_deframer_core uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin : monitor
    ard_result_t got;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        tags.note_byte(in_if.data_byte, in_if.stream_start);
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        got.byte_kind     = byte_kind_e'(out_if.byte_kind);
        got.byte_value    = out_if.byte_value;
        got.meta_index    = out_if.meta_index;
        got.item_last     = out_if.item_last;
        got.file_size     = out_if.file_size;
        got.size_overflow = out_if.size_overflow;
        got.version       = out_if.version;
        tags.check_tag(got);
        moved = 1'b1;
      end
    end
    idle_count = moved ? 0 : idle_count + 1;
    if (idle_count >= IdleLimit && !finished) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic restart);
    int gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= b;
    in_if.stream_start <= restart;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    bytes_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 39);
    if (r < 10) return 0;
    if (r == 39) return 255;
    return $urandom_range(1, 6);
  endfunction

  task automatic send_counted(input int len);
    send_byte(8'(len), 1'b0);
    send_random(len);
  endtask

  task automatic send_size(input int value);
    if (value >= 128) begin
      send_byte(8'h80 | 8'(value >> 7), 1'b0);
    end else if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) send_byte(8'h80, 1'b0);
    end
    send_byte(8'(value & 8'h7F), 1'b0);
  endtask

  task automatic send_archive(input int idx);
    int          ver_pick;
    int          len;
    logic [15:0] ver;
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_random(HeaderLen - 1);
    ver_pick = $urandom_range(0, 9);
    ver = (ver_pick < 4) ? 16'd1 : (ver_pick < 8) ? 16'd2 : 16'($urandom_range(0, 65535));
    send_byte(ver[15:8], 1'b0);
    send_byte(ver[7:0], 1'b0);
    if (ver != 16'd1 && ver != 16'd2) begin
      send_random($urandom_range(1, 6));
      return;
    end
    if (ver == 16'd2) begin
      repeat (MetaCount) send_counted(pick_len());
    end
    repeat ($urandom_range(1, 8)) begin
      ver_pick = $urandom_range(0, 19);
      if (ver_pick < 12) begin
        send_byte(RecFile, 1'b0);
        send_counted(pick_len() % 6);
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(128, 130) : $urandom_range(0, 6);
        send_size(len);
        send_random(len);
      end else if (ver_pick < 16) begin
        send_byte(RecMarker, 1'b0);
        send_counted(pick_len());
      end else begin
        send_byte(8'($urandom_range(1, 254)), 1'b0);
      end
    end
    // The stream is cut short after a huge size; the next archive restarts the parser.
    if (idx % 7 == 3) begin
      send_byte(RecFile, 1'b0);
      send_counted($urandom_range(0, 2));
      send_byte(8'h80 | 8'($urandom_range(16, 127)), 1'b0);
      repeat ($urandom_range(3, 5)) send_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
      send_byte(8'($urandom_range(0, 127)), 1'b0);
      send_random($urandom_range(1, 4));
    end else if (idx % 7 == 5) begin
      send_byte(RecFile, 1'b0);
      send_counted(0);
      send_byte(8'h8F, 1'b0);
      repeat (3) send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_random($urandom_range(1, 3));
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tags.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : receiver
    int n;
    out_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
      n = draw_wait(rx_calm);
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] directed[$];
    int         idx;
    bit         held;
    bit         drained;
    directed = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h00, 8'hFF,
                 8'h0D, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h7E, 8'h00, 8'h00, 8'h00, 8'hFF,
                 8'h00, 8'h00, 8'h01, 8'h41, 8'h02, 8'hAA, 8'h55, 8'hFF, 8'h01, 8'h5A};
    idx     = 0;
    held    = 1'b0;
    drained = 1'b0;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.data_byte    = '0;
    in_if.stream_start = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Version 1 stream: unknown type, empty file, empty marker, short file and marker.
    foreach (directed[i]) send_byte(directed[i], i == 0);

    while (bytes_sent < TargetSent) begin
      if (!held && bytes_sent > 400) begin
        hold_cycles = LongHold;
        held = 1'b1;
      end
      if (!drained && bytes_sent > 900) begin
        drain_results();
        drained = 1'b1;
      end
      send_archive(idx);
      idx++;
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 5))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    finished = 1'b1;
    if (tags.errors == 0 && tags.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl
rtl/ard_pkg.sv
rtl/ard_if.sv
rtl/ard_parser.sv
rtl/archive_record_deframer_core.sv
dv/archive_record_deframer_core_tb.sv
